[rtl/image_kernel_convolution_macros.svh]
// Assertion helpers for the RTL file that checks its own logic (ikc_queue).
`ifndef IMAGE_KERNEL_CONVOLUTION_MACROS_SVH
`define IMAGE_KERNEL_CONVOLUTION_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define IKC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ikc assertion failed");

// Next-cycle implication, disabled while reset is held.
`define IKC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ikc assertion failed");

`endif

[rtl/ikc_pkg.sv]
`default_nettype none
package ikc_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_KERNEL_DEF = 5;
  localparam int PIXEL_BITS_DEF = 8;
  localparam int COEF_BITS_DEF  = 8;

  localparam int MAX_ROWS    = 4096;
  localparam int ROW_W       = 12;
  localparam int COL_OUT_W   = 10;
  localparam int SUM_OUT_W   = 21;
  localparam int NCOEF       = 25;
  localparam int NCOEF_WORDS = 4;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int KSZ_W       = 3;
  localparam int IW_W        = 11;
  localparam int IH_W        = 13;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_HEIGHT,
    CFG_KERNEL_WIDTH,
    CFG_COEF_0,
    CFG_COEF_1,
    CFG_COEF_2,
    CFG_COEF_3,
    CFG_IMAGE_WIDTH,
    CFG_IMAGE_HEIGHT
  } ikc_cfg_idx_t;

  typedef struct packed {
    logic [KSZ_W-1:0] kernel_height;
    logic [KSZ_W-1:0] kernel_width;
    logic [IW_W-1:0]  image_width;
    logic [IH_W-1:0]  image_height;
  } ikc_geom_t;

  typedef logic [NCOEF_WORDS-1:0][CFG_W-1:0] ikc_coef_t;

  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
    logic                 last;
  } ikc_meta_t;

  // Kernel sizes of zero act as one, sizes above the window act as the window.
  function automatic logic [KSZ_W-1:0] clamp_ksize(input logic [KSZ_W-1:0] v,
                                                   input logic [KSZ_W-1:0] kmax);
    logic [KSZ_W-1:0] r;
    if (v == '0) begin
      r = KSZ_W'(1);
    end else if (v > kmax) begin
      r = kmax;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/ikc_pix_if.sv]
`default_nettype none
interface ikc_pix_if #(
  parameter int PIXEL_BITS = ikc_pkg::PIXEL_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface
`default_nettype wire

[rtl/ikc_res_if.sv]
`default_nettype none
interface ikc_res_if ();
  import ikc_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [SUM_OUT_W-1:0] sum_value;
  logic [ROW_W-1:0]            out_row;
  logic [COL_OUT_W-1:0]        out_col;
  logic                        frame_last;

  modport source (output valid, output sum_value, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink   (input valid, input sum_value, input out_row, input out_col,
                  input frame_last, output ready);
endinterface
`default_nettype wire

[rtl/ikc_front.sv]
`default_nettype none
module ikc_front #(
  parameter int MAX_WIDTH  = ikc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = ikc_pkg::MAX_KERNEL_DEF,
  parameter int PIXEL_BITS = ikc_pkg::PIXEL_BITS_DEF,
  parameter int QW         = $bits(ikc_pkg::ikc_meta_t) + MAX_KERNEL*MAX_KERNEL*PIXEL_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  ikc_pix_if.sink                pix,
  input  wire ikc_pkg::ikc_geom_t geom,
  input  wire logic              restart,
  input  wire logic              q_full,
  output logic                   push,
  output logic [QW-1:0]          push_data
);
  import ikc_pkg::*;

  localparam int LINES = MAX_KERNEL - 1;
  localparam int CA_W  = $clog2(MAX_WIDTH);
  localparam int IWE_W = $clog2(MAX_WIDTH + 1);
  localparam int RE_W  = ROW_W + 1;

  typedef logic [LINES-1:0][PIXEL_BITS-1:0] col_word_t;
  typedef logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][PIXEL_BITS-1:0] win_t;

  // Column store: each word holds the last LINES pixels seen at one column,
  // oldest in lane 0.
  col_word_t mem [MAX_WIDTH];

  logic [CA_W-1:0]       col_r, col_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic                  v1_r;
  logic [PIXEL_BITS-1:0] pix1_r;
  logic [CA_W-1:0]       c1_r;
  logic [ROW_W-1:0]      r1_r;
  col_word_t             rd_r;
  logic                  wr_vld_r;
  logic [CA_W-1:0]       wr_addr_r;
  col_word_t             wr_word_r;
  win_t                  win_r, win_nxt;

  logic [KSZ_W-1:0] kh_e, kw_e;
  logic [IWE_W-1:0] iw_e;
  logic [RE_W-1:0]  ih_e;
  logic [IWE_W-1:0] c_inc, c1_inc, col_ctr;
  logic [RE_W-1:0]  r_inc, r1_inc, row_ctr;
  col_word_t        colw, new_word;
  logic             accept, fire1, emit;
  ikc_meta_t        meta;

  assign kh_e = clamp_ksize(geom.kernel_height, KSZ_W'(MAX_KERNEL));
  assign kw_e = clamp_ksize(geom.kernel_width, KSZ_W'(MAX_KERNEL));

  always_comb begin
    if (geom.image_width == '0) begin
      iw_e = IWE_W'(1);
    end else if (32'(geom.image_width) > MAX_WIDTH) begin
      iw_e = IWE_W'(MAX_WIDTH);
    end else begin
      iw_e = IWE_W'(geom.image_width);
    end
    if (geom.image_height == '0) begin
      ih_e = RE_W'(1);
    end else if (32'(geom.image_height) > MAX_ROWS) begin
      ih_e = RE_W'(MAX_ROWS);
    end else begin
      ih_e = RE_W'(geom.image_height);
    end
  end

  assign emit   = (r1_inc >= RE_W'(kh_e)) && (c1_inc >= IWE_W'(kw_e));
  assign fire1  = v1_r && (!emit || !q_full);
  assign pix.ready = !v1_r || fire1;
  assign accept = pix.valid && pix.ready;
  assign push   = fire1 && emit;

  // Raster position of the next pixel.
  assign c_inc = IWE_W'(col_r) + IWE_W'(1);
  assign r_inc = RE_W'(row_r) + RE_W'(1);
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (c_inc >= iw_e) begin
        col_nxt = '0;
        row_nxt = (r_inc >= ih_e) ? '0 : ROW_W'(r_inc);
      end else begin
        col_nxt = CA_W'(c_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      v1_r     <= 1'b0;
      wr_vld_r <= 1'b0;
      win_r    <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (accept) begin
        v1_r <= 1'b1;
      end else if (fire1) begin
        v1_r <= 1'b0;
      end
      if (fire1) begin
        wr_vld_r <= 1'b1;
        win_r    <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix1_r <= pix.pixel;
      c1_r   <= col_r;
      r1_r   <= row_r;
      rd_r   <= mem[col_r];
    end
    if (fire1) begin
      mem[c1_r] <= new_word;
      wr_addr_r <= c1_r;
      wr_word_r <= new_word;
    end
  end

  // The pixel just ahead may have written this column after it was read.
  assign colw = (wr_vld_r && wr_addr_r == c1_r) ? wr_word_r : rd_r;

  always_comb begin
    for (int k = 0; k < LINES - 1; k++) begin
      new_word[k] = colw[k+1];
    end
    new_word[LINES-1] = pix1_r;
  end

  always_comb begin
    for (int k = 0; k < MAX_KERNEL; k++) begin
      for (int m = 0; m < MAX_KERNEL - 1; m++) begin
        win_nxt[k][m] = win_r[k][m+1];
      end
    end
    for (int k = 0; k < LINES; k++) begin
      win_nxt[k][MAX_KERNEL-1] = colw[k];
    end
    win_nxt[LINES][MAX_KERNEL-1] = pix1_r;
  end

  assign c1_inc  = IWE_W'(c1_r) + IWE_W'(1);
  assign r1_inc  = RE_W'(r1_r) + RE_W'(1);
  assign row_ctr = r1_inc - RE_W'(kh_e) + RE_W'(kh_e >> 1);
  assign col_ctr = c1_inc - IWE_W'(kw_e) + IWE_W'(kw_e >> 1);

  assign meta.row  = ROW_W'(row_ctr);
  assign meta.col  = COL_OUT_W'(col_ctr);
  assign meta.last = (r1_inc == ih_e) && (c1_inc == iw_e);

  assign push_data = {meta, win_nxt};
endmodule
`default_nettype wire

[rtl/ikc_queue.sv]
`default_nettype none
`include "image_kernel_convolution_macros.svh"
module ikc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ikc_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head,
  output logic                  full,
  output logic                  empty
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  `IKC_ASSERT_NOW(a_no_push_full, clk, rst_n, push, !full)
  `IKC_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, !empty)
  `IKC_ASSERT_NOW(a_fill_tracks_ptrs, clk, rst_n, !full, PTR_W'(cnt_r) == wr_ptr_r - rd_ptr_r)
endmodule
`default_nettype wire

[rtl/ikc_back.sv]
`default_nettype none
module ikc_back #(
  parameter int MAX_KERNEL = ikc_pkg::MAX_KERNEL_DEF,
  parameter int PIXEL_BITS = ikc_pkg::PIXEL_BITS_DEF,
  parameter int COEF_BITS  = ikc_pkg::COEF_BITS_DEF,
  parameter int QW         = $bits(ikc_pkg::ikc_meta_t) + MAX_KERNEL*MAX_KERNEL*PIXEL_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ikc_pkg::ikc_geom_t geom,
  input  wire ikc_pkg::ikc_coef_t coef,
  input  wire logic               q_empty,
  input  wire logic [QW-1:0]      q_head,
  output logic                    pop,
  ikc_res_if.source               res
);
  import ikc_pkg::*;

  localparam int CW    = (COEF_BITS < 8) ? COEF_BITS : 8;
  localparam int PW    = PIXEL_BITS + CW + 1;
  localparam int RS_W  = PW + $clog2(MAX_KERNEL);
  localparam int SUM_W = PW + $clog2(MAX_KERNEL * MAX_KERNEL);
  localparam int IDX_W = 6;

  typedef logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][PIXEL_BITS-1:0] win_t;

  logic signed [CW-1:0]    coef_pos_r [MAX_KERNEL][MAX_KERNEL];
  logic signed [CW-1:0]    coef_pos_nxt [MAX_KERNEL][MAX_KERNEL];
  logic signed [PW-1:0]    prod_r [MAX_KERNEL][MAX_KERNEL];
  logic signed [RS_W-1:0]  rsum_r [MAX_KERNEL];
  logic signed [SUM_W-1:0] total;
  logic                    va_r, vb_r, vo_r;
  ikc_meta_t               meta_a_r, meta_b_r, meta_o_r;
  logic signed [SUM_OUT_W-1:0] sum_o_r;
  logic                    en;
  ikc_meta_t               q_meta;
  win_t                    q_win;
  logic [KSZ_W-1:0]        kh_e, kw_e;

  function automatic logic signed [RS_W-1:0] row_sum(input int a);
    logic signed [RS_W-1:0] s;
    s = '0;
    for (int b = 0; b < MAX_KERNEL; b++) begin
      s = s + RS_W'(prod_r[a][b]);
    end
    return s;
  endfunction

  assign kh_e = clamp_ksize(geom.kernel_height, KSZ_W'(MAX_KERNEL));
  assign kw_e = clamp_ksize(geom.kernel_width, KSZ_W'(MAX_KERNEL));

  // Coefficient seen by each window position for the current kernel size.
  always_comb begin
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] word;
    logic [7:0]       byte_v;
    for (int a = 0; a < MAX_KERNEL; a++) begin
      for (int b = 0; b < MAX_KERNEL; b++) begin
        idx    = IDX_W'(a - (MAX_KERNEL - 32'(kh_e))) * IDX_W'(kw_e)
               + IDX_W'(b - (MAX_KERNEL - 32'(kw_e)));
        word   = coef[idx[4:3]];
        byte_v = word[{idx[2:0], 3'b000} +: 8];
        if (a >= MAX_KERNEL - 32'(kh_e) && b >= MAX_KERNEL - 32'(kw_e) &&
            32'(idx) < NCOEF) begin
          coef_pos_nxt[a][b] = signed'(byte_v[CW-1:0]);
        end else begin
          coef_pos_nxt[a][b] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    coef_pos_r <= coef_pos_nxt;
  end

  assign en  = !vo_r || res.ready;
  assign pop = en && !q_empty;
  assign {q_meta, q_win} = q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      va_r <= !q_empty;
      vb_r <= va_r;
      vo_r <= vb_r;
    end
  end

  always_comb begin
    total = '0;
    for (int a = 0; a < MAX_KERNEL; a++) begin
      total = total + SUM_W'(rsum_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_a_r <= q_meta;
      for (int a = 0; a < MAX_KERNEL; a++) begin
        for (int b = 0; b < MAX_KERNEL; b++) begin
          prod_r[a][b] <= PW'(signed'({1'b0, q_win[a][b]})) * PW'(coef_pos_r[a][b]);
        end
      end
      meta_b_r <= meta_a_r;
      for (int a = 0; a < MAX_KERNEL; a++) begin
        rsum_r[a] <= row_sum(a);
      end
      meta_o_r <= meta_b_r;
      sum_o_r  <= SUM_OUT_W'(total);
    end
  end

  assign res.valid      = vo_r;
  assign res.sum_value  = sum_o_r;
  assign res.out_row    = meta_o_r.row;
  assign res.out_col    = meta_o_r.col;
  assign res.frame_last = meta_o_r.last;
endmodule
`default_nettype wire

[rtl/image_kernel_convolution.sv]
// Streaming 2-D correlation of a grey image with a kernel of up to
// MAX_KERNEL x MAX_KERNEL signed coefficients, without flip or scaling.
// in_pix carries one pixel per beat in raster order. out_res carries one
// beat for every pixel that completes a full kernel window: the sum, the
// row and column of the window center, and frame_last on the frame's final
// result. Border positions give no beat.
// Throughput is one pixel per clock while the queue is not full: the column
// store is read when a pixel is taken and written as it leaves the window
// stage, so every pixel costs one store port slot. A result then passes the
// queue, which the window stage pushes into, and the product, row-sum and
// output registers, the last holding the total. Configuration goes through
// cfg_wr_en/cfg_index/cfg_wdata; the user must write it only while the block
// is idle, which it does not enforce; a geometry write restarts the frame at row 0.
// Reset (rst_n low at a clock edge) restores the default registers, empties
// the pipeline and clears the window; the column store needs no clearing.
// When out_res is stalled the back end holds, the four-entry queue fills,
// and then in_pix.ready drops until the sink takes results again.
`default_nettype none
module image_kernel_convolution #(
  parameter int MAX_WIDTH  = ikc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = ikc_pkg::MAX_KERNEL_DEF,
  parameter int PIXEL_BITS = ikc_pkg::PIXEL_BITS_DEF,
  parameter int COEF_BITS  = ikc_pkg::COEF_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ikc_pix_if.sink                            in_pix,
  ikc_res_if.source                          out_res,
  input  wire logic                          cfg_wr_en,
  input  wire logic [ikc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ikc_pkg::CFG_W-1:0]     cfg_wdata
);
  import ikc_pkg::*;

  // Queue entry: result position, frame-end flag and the full window snapshot.
  localparam int QW = $bits(ikc_meta_t) + MAX_KERNEL * MAX_KERNEL * PIXEL_BITS;

  ikc_geom_t geom_r;
  ikc_coef_t coef_r;
  logic      restart;
  logic      push, pop, q_full, q_empty;
  logic [QW-1:0] push_data, q_head;

  // Register file. Coefficient writes take effect without a restart; geometry writes also
  // send the front end back to the first pixel of a frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.kernel_height <= KSZ_W'(3);
      geom_r.kernel_width  <= KSZ_W'(3);
      geom_r.image_width   <= IW_W'(1024);
      geom_r.image_height  <= IH_W'(1024);
      coef_r               <= '0;
    end else if (cfg_wr_en) begin
      unique case (ikc_cfg_idx_t'(cfg_index))
        CFG_KERNEL_HEIGHT: geom_r.kernel_height <= cfg_wdata[KSZ_W-1:0];
        CFG_KERNEL_WIDTH:  geom_r.kernel_width  <= cfg_wdata[KSZ_W-1:0];
        CFG_COEF_0:        coef_r[0] <= cfg_wdata;
        CFG_COEF_1:        coef_r[1] <= cfg_wdata;
        CFG_COEF_2:        coef_r[2] <= cfg_wdata;
        CFG_COEF_3:        coef_r[3] <= {{(CFG_W-8){1'b0}}, cfg_wdata[7:0]};
        CFG_IMAGE_WIDTH:   geom_r.image_width  <= cfg_wdata[IW_W-1:0];
        CFG_IMAGE_HEIGHT:  geom_r.image_height <= cfg_wdata[IH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    restart = 1'b0;
    if (cfg_wr_en) begin
      unique case (ikc_cfg_idx_t'(cfg_index))
        CFG_KERNEL_HEIGHT, CFG_KERNEL_WIDTH,
        CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT: restart = 1'b1;
        default:                           restart = 1'b0;
      endcase
    end
  end

  // Front: raster counters, column store, sliding window, classification.
  ikc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL),
    .PIXEL_BITS (PIXEL_BITS),
    .QW         (QW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix       (in_pix),
    .geom      (geom_r),
    .restart   (restart),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Short queue decouples window building from the arithmetic.
  ikc_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: parallel products, row sums, total and the output register.
  ikc_back #(
    .MAX_KERNEL (MAX_KERNEL),
    .PIXEL_BITS (PIXEL_BITS),
    .COEF_BITS  (COEF_BITS),
    .QW         (QW)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .geom    (geom_r),
    .coef    (coef_r),
    .q_empty (q_empty),
    .q_head  (q_head),
    .pop     (pop),
    .res     (out_res)
  );
endmodule
`default_nettype wire

[sim/tb.sv]
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ikc_pkg::*;

  // One expected result beat: the window sum and where it lands in the frame.
  typedef struct {
    logic signed [SUM_OUT_W-1:0] sum_value;
    logic [ROW_W-1:0]            row;
    logic [COL_OUT_W-1:0]        col;
    logic                        last;
  } conv_result_t;

  localparam int RUN_LIMIT = 2_000_000;
  localparam int WIN       = MAX_KERNEL_DEF;
  localparam int LINES     = WIN - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  ikc_pix_if in_if ();
  ikc_res_if out_if ();

  image_kernel_convolution i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_if),
    .out_res  (out_if),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // The clock has a 4 ns period. The cycle counter doubles as the watchdog
  // that stops a run which has hung on a handshake.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  int unsigned cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Shadow copy of the block's registers and datapath state. The predictor
  // works on these and never looks inside the block.
  logic [KSZ_W-1:0] ker_h = 3, ker_w = 3;
  logic [IW_W-1:0]  img_w = 1024;
  logic [IH_W-1:0]  img_h = 1024;
  logic [CFG_W-1:0] coef_words [NCOEF_WORDS] = '{default: '0};
  int               row_pos = 0, col_pos = 0;
  logic [7:0]       lines_mem [LINES][MAX_WIDTH_DEF] = '{default: '0};
  logic [7:0]       win [WIN][WIN] = '{default: '0};

  logic [7:0]   pix_q [$];
  conv_result_t sums_due [$];
  int           errors = 0;
  int           pixels_sent = 0, results_seen = 0, frames_closed = 0;
  bit           calm = 1'b0;

  function automatic int clampv(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int coef_of(int idx);
    logic [CFG_W-1:0] w;
    w = coef_words[idx / 8];
    return int'($signed(w[(idx % 8) * 8 +: 8]));
  endfunction

  // Mirror of a register write. Any geometry write sends the frame back
  // to row 0, column 0; coefficient writes leave the position alone.
  function automatic void shadow_write(ikc_cfg_idx_t idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_KERNEL_HEIGHT: ker_h = val[KSZ_W-1:0];
      CFG_KERNEL_WIDTH:  ker_w = val[KSZ_W-1:0];
      CFG_COEF_0:        coef_words[0] = val;
      CFG_COEF_1:        coef_words[1] = val;
      CFG_COEF_2:        coef_words[2] = val;
      CFG_COEF_3:        coef_words[3] = {56'd0, val[7:0]};
      CFG_IMAGE_WIDTH:   img_w = val[IW_W-1:0];
      CFG_IMAGE_HEIGHT:  img_h = val[IH_W-1:0];
      default: ;
    endcase
    if (!(idx inside {CFG_COEF_0, CFG_COEF_1, CFG_COEF_2, CFG_COEF_3})) begin
      row_pos = 0;
      col_pos = 0;
    end
  endfunction

  // Takes one accepted pixel through the window and line stores, and queues
  // the correlation result when the pixel closes a full kernel window.
  function automatic void correlate_pixel(logic [7:0] pix);
    int kh, kw, iw, ih, r, c, acc;
    conv_result_t res;
    kh = clampv(ker_h, 1, WIN);
    kw = clampv(ker_w, 1, WIN);
    iw = clampv(img_w, 1, MAX_WIDTH_DEF);
    ih = clampv(img_h, 1, MAX_ROWS);
    r = (row_pos >= ih) ? ih - 1 : row_pos;
    c = (col_pos >= iw) ? iw - 1 : col_pos;
    for (int k = 0; k < WIN; k++)
      for (int m = 0; m < WIN - 1; m++)
        win[k][m] = win[k][m + 1];
    for (int k = 0; k < LINES; k++)
      win[k][WIN - 1] = lines_mem[(r + k) % LINES][c];
    win[LINES][WIN - 1] = pix;
    lines_mem[r % LINES][c] = pix;
    if (r + 1 >= kh && c + 1 >= kw) begin
      acc = 0;
      for (int i = 0; i < kh; i++)
        for (int j = 0; j < kw; j++)
          acc += coef_of(i * kw + j) * int'(win[WIN - kh + i][WIN - kw + j]);
      res.sum_value = acc[SUM_OUT_W-1:0];
      res.row = ROW_W'(r + 1 - kh + kh / 2);
      res.col = COL_OUT_W'(c + 1 - kw + kw / 2);
      res.last = (r + 1 == ih && c + 1 == iw);
      sums_due.push_back(res);
    end
    c++;
    if (c >= iw) begin
      c = 0;
      r++;
      if (r >= ih) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endfunction

  // Pixel driver. A beat stays on the bus until it is taken; between beats
  // it may insert a random idle gap, except in the calm tail.
  int in_gap = 0;
  always @(posedge clk) begin
    logic nv;
    logic [7:0] np;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.pixel <= '0;
      in_gap = 0;
    end else begin
      nv = in_if.valid;
      np = in_if.pixel;
      if (in_if.valid && in_if.ready) begin
        correlate_pixel(in_if.pixel);
        void'(pix_q.pop_front());
        pixels_sent++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 7);
        end else if (pix_q.size() != 0) begin
          nv = 1'b1;
          np = pix_q[0];
        end
      end
      in_if.valid <= nv;
      in_if.pixel <= np;
    end
  end

  // Result monitor. Every taken beat is checked against the oldest
  // expectation; ready drops in random bursts to back up the pipeline.
  int out_stall = 0;
  always @(posedge clk) begin
    conv_result_t exp_r;
    logic nr;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (sums_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat sum %0d row %0d col %0d last %0b", $time,
                   out_if.sum_value, out_if.out_row, out_if.out_col, out_if.frame_last);
        end else begin
          exp_r = sums_due.pop_front();
          if (exp_r.last) frames_closed++;
          if (out_if.sum_value !== exp_r.sum_value || out_if.out_row !== exp_r.row ||
              out_if.out_col !== exp_r.col || out_if.frame_last !== exp_r.last) begin
            errors++;
            $write("%0t: mismatch expected sum %0d row %0d col %0d last %0b,",
                   $time, exp_r.sum_value, exp_r.row, exp_r.col, exp_r.last);
            $display(" actual sum %0d row %0d col %0d last %0b",
                     out_if.sum_value, out_if.out_row, out_if.out_col, out_if.frame_last);
          end
        end
      end
      nr = 1'b1;
      if (out_stall > 0) begin
        out_stall--;
        nr = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall = $urandom_range(1, 7) - 1;
        nr = 1'b0;
      end
      out_if.ready <= nr;
    end
  end

  // Register write: the enable is high for one edge, and the shadow copy
  // is updated as the enable is driven, which is safe since the block is idle.
  task automatic write_reg(ikc_cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    shadow_write(idx, val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Waits until every queued pixel has been taken and every expected result
  // has come back, then lets the four-stage pipeline run empty, because a
  // pixel at a border position leaves no result to wait for.
  task automatic drain();
    do @(negedge clk);
    while (pix_q.size() != 0 || in_if.valid || sums_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] rand_coefs();
    case ($urandom_range(0, 5))
      0:       return {8{8'h80}};
      1:       return {8{8'h7F}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int rand_ksize();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5);
  endfunction

  // Pushes whole frames plus a partial one, so the next geometry write
  // sometimes lands in the middle of a frame.
  task automatic queue_frames(int frames);
    int n;
    n = frames * clampv(img_w, 1, MAX_WIDTH_DEF) * clampv(img_h, 1, MAX_ROWS)
        + $urandom_range(0, clampv(img_w, 1, MAX_WIDTH_DEF));
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       pix_q.push_back(8'h00);
        1:       pix_q.push_back(8'hFF);
        default: pix_q.push_back(8'($urandom));
      endcase
    end
  endtask

  int random_items = 0;
  int phase = 0;
  int before_cnt;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a full 5x5 window of white pixels against the most negative
    // coefficients gives the lowest possible sum; then the most positive
    // kernel on a 1x1 window, including black and white pixels.
    write_reg(CFG_KERNEL_HEIGHT, 5);
    write_reg(CFG_KERNEL_WIDTH, 5);
    write_reg(CFG_COEF_0, {8{8'h80}});
    write_reg(CFG_COEF_1, {8{8'h80}});
    write_reg(CFG_COEF_2, {8{8'h80}});
    write_reg(CFG_COEF_3, 8'h80);
    write_reg(CFG_IMAGE_WIDTH, 5);
    write_reg(CFG_IMAGE_HEIGHT, 5);
    @(negedge clk);
    repeat (25) pix_q.push_back(8'hFF);
    drain();
    write_reg(CFG_KERNEL_HEIGHT, 1);
    write_reg(CFG_KERNEL_WIDTH, 1);
    write_reg(CFG_COEF_0, 64'h7F);
    write_reg(CFG_IMAGE_WIDTH, 4);
    write_reg(CFG_IMAGE_HEIGHT, 1);
    @(negedge clk);
    pix_q.push_back(8'hFF);
    pix_q.push_back(8'h00);
    pix_q.push_back(8'h80);
    pix_q.push_back(8'h7F);
    drain();

    // Random phases. Most frames are tiny; one phase takes the widest line,
    // with width and height beyond range, and wraps into the second row.
    // Sizes of zero and beyond range are mixed in.
    while (random_items < 1200) begin
      if (random_items > 1000) calm = 1'b1;
      if (phase == 3) begin
        write_reg(CFG_KERNEL_HEIGHT, 1);
        write_reg(CFG_KERNEL_WIDTH, 5);
        write_reg(CFG_IMAGE_WIDTH, 11'h7FF);
        write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
        write_reg(CFG_COEF_0, rand_coefs());
        before_cnt = pix_q.size();
        @(negedge clk);
        repeat (MAX_WIDTH_DEF + 8) pix_q.push_back(8'($urandom));
        random_items += pix_q.size() - before_cnt;
      end else begin
        if (phase == 0 || $urandom_range(0, 2) != 0)
          write_reg(CFG_KERNEL_HEIGHT, rand_ksize());
        if (phase == 0 || $urandom_range(0, 2) != 0)
          write_reg(CFG_KERNEL_WIDTH, rand_ksize());
        if (phase == 0 || $urandom_range(0, 2) != 0)
          write_reg(CFG_IMAGE_WIDTH, ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 12));
        if (phase == 0 || $urandom_range(0, 2) != 0)
          write_reg(CFG_IMAGE_HEIGHT, ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8));
        for (int w = 0; w < NCOEF_WORDS; w++)
          if (phase == 0 || $urandom_range(0, 1) != 0)
            write_reg(ikc_cfg_idx_t'(int'(CFG_COEF_0) + w), rand_coefs());
        before_cnt = pix_q.size();
        queue_frames($urandom_range(1, 3));
        random_items += pix_q.size() - before_cnt;
      end
      drain();
      phase++;
    end

    $display("Covered %0d pixels in %0d random phases, %0d results, %0d frame ends",
             pixels_sent, phase, results_seen, frames_closed);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Errors: %0d", errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
+incdir+rtl
rtl/ikc_pkg.sv
rtl/ikc_pix_if.sv
rtl/ikc_res_if.sv
rtl/ikc_front.sv
rtl/ikc_queue.sv
rtl/ikc_back.sv
rtl/image_kernel_convolution.sv
sim/tb.sv
